### rtl/core/egm_pkg.sv
// Shared constants, register map and sequencer states of the ElGamal encryption core.
package egm_pkg;

  localparam int unsigned WORD_BITS_DEF = 32;

  localparam int unsigned MODULUS_P_RST   = 23;
  localparam int unsigned GENERATOR_G_RST = 5;
  localparam int unsigned PUBLIC_Y_RST    = 1;

  typedef logic [1:0] egm_reg_idx_t;

  localparam egm_reg_idx_t REG_MODULUS_P   = 2'd0;
  localparam egm_reg_idx_t REG_GENERATOR_G = 2'd1;
  localparam egm_reg_idx_t REG_PUBLIC_Y    = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_REDUCE_M,
    ST_MUL,
    ST_SQR,
    ST_FINAL
  } egm_state_e;

endpackage

### rtl/core/elgamal_encrypt_modexp_core.sv
// ElGamal encryption core: key registers, exponentiation sequencer and two serial multipliers.
//
// Usage: write the public key (modulus_p at 0x0, generator_g at 0x4, public_y at 0x8)
// through the APB port while the core is idle. Start a transaction by raising start
// with plaintext_i and ephemeral_k_i while busy is low; the inputs are taken at that edge.
// The core returns c1 = g^k mod p and c2 = m * y^k mod p on cipher_c1_o / cipher_c2_o,
// marked by valid_o for exactly one cycle; the receiver cannot stall, so no result waits.
// The sequencer reduces g and y mod p, then m, then walks k from its low bit, squaring
// between bits, and ends with the product m * y^k. Each modular product runs in a
// bit-serial multiplier; the g and y chains run in lockstep on two multipliers, and the
// ones of k add one multiply step each. One transaction is in flight at a time; busy
// stays high until the cycle of valid_o. A modulus below 2 returns zeros in the cycle
// after accept.
// Reset: key registers return to p = 23, g = 5, y = 1; the sequencer goes idle and any
// transaction in flight is dropped.
module elgamal_encrypt_modexp_core import egm_pkg::*; #(
  parameter  int unsigned WORD_BITS = WORD_BITS_DEF,
  localparam int unsigned DATA_W    = (WORD_BITS > 32) ? 64 : 32,
  localparam int unsigned ALIGN     = (WORD_BITS > 32) ? 3 : 2,
  localparam int unsigned ADDR_W    = ALIGN + 2
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [ADDR_W-1:0]    paddr,
  input  logic [DATA_W-1:0]    pwdata,
  output logic [DATA_W-1:0]    prdata,
  output logic                 pready,
  input  logic                 start,
  output logic                 busy,
  input  logic [WORD_BITS-1:0] plaintext_i,
  input  logic [WORD_BITS-1:0] ephemeral_k_i,
  output logic                 valid_o,
  output logic [WORD_BITS-1:0] cipher_c1_o,
  output logic [WORD_BITS-1:0] cipher_c2_o
);

  localparam int unsigned BW = $clog2(WORD_BITS);
  localparam logic [WORD_BITS-1:0] ONE = WORD_BITS'(1);

  logic [WORD_BITS-1:0] p_q, g_q, y_q;
  egm_reg_idx_t         reg_idx;
  logic                 cfg_wr;

  egm_state_e           state_q, state_d;
  logic                 go_q, launch;
  logic [WORD_BITS-1:0] k_q, k_d, m_q, m_d;
  logic [BW-1:0]        bit_q, bit_d;
  logic [WORD_BITS-1:0] accg_q, accg_d, sqg_q, sqg_d;
  logic [WORD_BITS-1:0] accy_q, accy_d, sqy_q, sqy_d;
  logic [WORD_BITS-1:0] mr_q, mr_d;
  logic [WORD_BITS-1:0] c1_q, c1_d, c2_q, c2_d;
  logic                 valid_q, valid_d;
  logic                 last_bit, next_last, p_small;

  logic                 start_a, start_b, done_a, done_b;
  logic [WORD_BITS-1:0] a_a, b_a, a_b, b_b, r_a, r_b;

  assign reg_idx = paddr[ADDR_W-1:ALIGN];
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_q <= WORD_BITS'(MODULUS_P_RST);
      g_q <= WORD_BITS'(GENERATOR_G_RST);
      y_q <= WORD_BITS'(PUBLIC_Y_RST);
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_MODULUS_P:   p_q <= pwdata[WORD_BITS-1:0];
        REG_GENERATOR_G: g_q <= pwdata[WORD_BITS-1:0];
        REG_PUBLIC_Y:    y_q <= pwdata[WORD_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_MODULUS_P:   prdata = DATA_W'(p_q);
      REG_GENERATOR_G: prdata = DATA_W'(g_q);
      REG_PUBLIC_Y:    prdata = DATA_W'(y_q);
      default:         prdata = '0;
    endcase
  end

  assign last_bit  = (bit_q == BW'(WORD_BITS - 1));
  assign next_last = (bit_q == BW'(WORD_BITS - 2));
  assign p_small   = (p_q < WORD_BITS'(2));

  always_comb begin
    state_d = state_q;
    launch  = 1'b0;
    k_d     = k_q;
    m_d     = m_q;
    bit_d   = bit_q;
    accg_d  = accg_q;
    sqg_d   = sqg_q;
    accy_d  = accy_q;
    sqy_d   = sqy_q;
    mr_d    = mr_q;
    c1_d    = c1_q;
    c2_d    = c2_q;
    valid_d = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (start) begin
          if (p_small) begin
            c1_d    = '0;
            c2_d    = '0;
            valid_d = 1'b1;
          end else begin
            k_d     = ephemeral_k_i;
            m_d     = plaintext_i;
            bit_d   = '0;
            state_d = ST_REDUCE;
            launch  = 1'b1;
          end
        end
      end
      ST_REDUCE: begin
        if (done_a) begin
          sqg_d   = r_a;
          sqy_d   = r_b;
          accg_d  = ONE;
          accy_d  = ONE;
          state_d = ST_REDUCE_M;
          launch  = 1'b1;
        end
      end
      ST_REDUCE_M: begin
        if (done_a) begin
          mr_d   = r_a;
          launch = 1'b1;
          if (k_q[0]) begin
            state_d = ST_MUL;
          end else begin
            state_d = last_bit ? ST_FINAL : ST_SQR;
          end
        end
      end
      ST_MUL: begin
        if (done_a) begin
          accg_d  = r_a;
          accy_d  = r_b;
          launch  = 1'b1;
          state_d = last_bit ? ST_FINAL : ST_SQR;
        end
      end
      ST_SQR: begin
        if (done_a) begin
          sqg_d  = r_a;
          sqy_d  = r_b;
          k_d    = {1'b0, k_q[WORD_BITS-1:1]};
          bit_d  = bit_q + BW'(1);
          launch = 1'b1;
          if (k_q[1]) begin
            state_d = ST_MUL;
          end else begin
            state_d = next_last ? ST_FINAL : ST_SQR;
          end
        end
      end
      ST_FINAL: begin
        if (done_b) begin
          c1_d    = accg_q;
          c2_d    = r_b;
          valid_d = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    a_a = '0;
    b_a = '0;
    a_b = '0;
    b_b = '0;
    case (state_q)
      ST_REDUCE: begin
        a_a = ONE;
        b_a = g_q;
        a_b = ONE;
        b_b = y_q;
      end
      ST_REDUCE_M: begin
        a_a = ONE;
        b_a = m_q;
      end
      ST_MUL: begin
        a_a = accg_q;
        b_a = sqg_q;
        a_b = accy_q;
        b_b = sqy_q;
      end
      ST_SQR: begin
        a_a = sqg_q;
        b_a = sqg_q;
        a_b = sqy_q;
        b_b = sqy_q;
      end
      ST_FINAL: begin
        a_b = mr_q;
        b_b = accy_q;
      end
      default: ;
    endcase
  end

  assign start_a = go_q && (state_q == ST_REDUCE || state_q == ST_REDUCE_M ||
                            state_q == ST_MUL || state_q == ST_SQR);
  assign start_b = go_q && (state_q == ST_REDUCE || state_q == ST_MUL ||
                            state_q == ST_SQR || state_q == ST_FINAL);

  egm_modmul #(
    .WORD_BITS(WORD_BITS)
  ) u_mul_g (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_a),
    .a_i    (a_a),
    .b_i    (b_a),
    .m_i    (p_q),
    .done_o (done_a),
    .r_o    (r_a)
  );

  egm_modmul #(
    .WORD_BITS(WORD_BITS)
  ) u_mul_y (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_b),
    .a_i    (a_b),
    .b_i    (b_b),
    .m_i    (p_q),
    .done_o (done_b),
    .r_o    (r_b)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      go_q    <= 1'b0;
      valid_q <= 1'b0;
      bit_q   <= '0;
    end else begin
      state_q <= state_d;
      go_q    <= launch;
      valid_q <= valid_d;
      bit_q   <= bit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    k_q    <= k_d;
    m_q    <= m_d;
    accg_q <= accg_d;
    sqg_q  <= sqg_d;
    accy_q <= accy_d;
    sqy_q  <= sqy_d;
    mr_q   <= mr_d;
    c1_q   <= c1_d;
    c2_q   <= c2_d;
  end

  assign busy        = (state_q != ST_IDLE);
  assign valid_o     = valid_q;
  assign cipher_c1_o = c1_q;
  assign cipher_c2_o = c2_q;

endmodule

### rtl/core/egm_modmul.sv
// Bit-serial modular multiplier: r = a * b mod m, one bit of b per cycle, top bit first.
module egm_modmul import egm_pkg::*; #(
  parameter int unsigned WORD_BITS = WORD_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [WORD_BITS-1:0] a_i,
  input  logic [WORD_BITS-1:0] b_i,
  input  logic [WORD_BITS-1:0] m_i,
  output logic                 done_o,
  output logic [WORD_BITS-1:0] r_o
);

  localparam int unsigned CW = $clog2(WORD_BITS);

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [CW-1:0]        cnt_q, cnt_d;
  logic [WORD_BITS-1:0] r_q, r_d;
  logic [WORD_BITS-1:0] b_q, b_d;

  logic [WORD_BITS:0]   dbl, dbl_sub, sum, sum_sub, m_ext;
  logic [WORD_BITS-1:0] dbl_red, sum_red;

  always_comb begin
    m_ext   = {1'b0, m_i};
    dbl     = {r_q, 1'b0};
    dbl_sub = dbl - m_ext;
    dbl_red = (dbl >= m_ext) ? dbl_sub[WORD_BITS-1:0] : dbl[WORD_BITS-1:0];
    sum     = {1'b0, dbl_red} + {1'b0, a_i};
    sum_sub = sum - m_ext;
    sum_red = (sum >= m_ext) ? sum_sub[WORD_BITS-1:0] : sum[WORD_BITS-1:0];
  end

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    r_d    = r_q;
    b_d    = b_q;
    if (start_i) begin
      r_d    = '0;
      b_d    = b_i;
      cnt_d  = CW'(WORD_BITS - 1);
      busy_d = 1'b1;
    end else if (busy_q) begin
      r_d = b_q[WORD_BITS-1] ? sum_red : dbl_red;
      b_d = {b_q[WORD_BITS-2:0], 1'b0};
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        cnt_d = cnt_q - CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    r_q <= r_d;
    b_q <= b_d;
  end

  assign done_o = done_q;
  assign r_o    = r_q;

endmodule

### bench/tb_elgamal_encrypt_modexp_core.sv
// Self-checking testbench for the ElGamal encryption core: directed vectors, then random key phases.
module tb_elgamal_encrypt_modexp_core;
  import egm_pkg::*;

  localparam int unsigned WORD_BITS      = 32;
  localparam int unsigned PHASE_ITEMS    = 42;
  localparam int unsigned RANDOM_PHASES  = 6;
  localparam int unsigned LONG_GAP_MAX   = 2400;
  localparam int unsigned TAIL_CYCLES    = 2300;
  localparam int unsigned TIMEOUT_CYCLES = 8000000;
  localparam egm_reg_idx_t REG_UNMAPPED  = 2'd3;

  typedef logic [WORD_BITS-1:0] word_t;

  typedef struct packed {
    word_t c1;
    word_t c2;
  } cipher_t;

  typedef struct packed {
    word_t   p;
    word_t   g;
    word_t   y;
    word_t   m;
    word_t   k;
    logic    typed;
    cipher_t res;
  } vector_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        psel          = 1'b0;
  logic        penable       = 1'b0;
  logic        pwrite        = 1'b0;
  logic [3:0]  paddr         = '0;
  logic [31:0] pwdata        = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        start         = 1'b0;
  logic        busy;
  word_t       plaintext_i   = '0;
  word_t       ephemeral_k_i = '0;
  logic        valid_o;
  word_t       cipher_c1_o;
  word_t       cipher_c2_o;

  word_t       key_p = word_t'(MODULUS_P_RST);
  word_t       key_g = word_t'(GENERATOR_G_RST);
  word_t       key_y = word_t'(PUBLIC_Y_RST);

  cipher_t     pending_ciphers [$];
  int unsigned error_count     = 0;
  int unsigned ciphers_checked = 0;
  int unsigned key_changes     = 0;
  int unsigned gap_percent     = 0;

  vector_t directed_vectors [0:18] = '{
    '{32'd23, 32'd5, 32'd1, 32'd0, 32'd0, 1'b1, '{32'd1, 32'd0}},
    '{32'd23, 32'd5, 32'd1, 32'd22, 32'd1, 1'b1, '{32'd5, 32'd22}},
    '{32'd23, 32'd5, 32'd1, 32'd23, 32'd1, 1'b1, '{32'd5, 32'd0}},
    '{32'd23, 32'd5, 32'd1, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b0, '0},
    '{32'd23, 32'd5, 32'd1, 32'h00003039, 32'd2, 1'b0, '0},
    '{32'd0, 32'd5, 32'd7, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b1, '{32'd0, 32'd0}},
    '{32'd0, 32'd5, 32'd7, 32'd1, 32'd0, 1'b1, '{32'd0, 32'd0}},
    '{32'd1, 32'd0, 32'hFFFFFFFF, 32'd5, 32'd3, 1'b1, '{32'd0, 32'd0}},
    '{32'd2, 32'd3, 32'd3, 32'd3, 32'd5, 1'b0, '0},
    '{32'd2, 32'd3, 32'd3, 32'hFFFFFFFF, 32'd0, 1'b0, '0},
    '{32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFE, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b1,
      '{32'd0, 32'd0}},
    '{32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFE, 32'hFFFFFFFE, 32'd1, 1'b0, '0},
    '{32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFE, 32'd0, 32'd0, 1'b1, '{32'd1, 32'd0}},
    '{32'hFFFFFFFB, 32'd2, 32'h80000000, 32'd0, 32'hFFFFFFFF, 1'b0, '0},
    '{32'hFFFFFFFB, 32'd2, 32'h80000000, 32'hFFFFFFFA, 32'h80000000, 1'b0, '0},
    '{32'hFFFFFFFB, 32'd2, 32'h80000000, 32'h55555555, 32'hAAAAAAAA, 1'b0, '0},
    '{32'hFFFFFFFB, 32'd2, 32'h80000000, 32'hFFFFFFFB, 32'd1, 1'b1, '{32'd2, 32'd0}},
    '{32'd3, 32'd0, 32'd0, 32'hFFFFFFFF, 32'd1, 1'b1, '{32'd0, 32'd0}},
    '{32'd3, 32'd0, 32'd0, 32'd2, 32'd0, 1'b1, '{32'd1, 32'd2}}
  };

  elgamal_encrypt_modexp_core u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .start         (start),
    .busy          (busy),
    .plaintext_i   (plaintext_i),
    .ephemeral_k_i (ephemeral_k_i),
    .valid_o       (valid_o),
    .cipher_c1_o   (cipher_c1_o),
    .cipher_c2_o   (cipher_c2_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic word_t mul_mod(word_t a, word_t b, word_t m);
    logic [2*WORD_BITS-1:0] prod;
    prod = {{WORD_BITS{1'b0}}, a} * {{WORD_BITS{1'b0}}, b};
    return word_t'(prod % {{WORD_BITS{1'b0}}, m});
  endfunction

  function automatic word_t pow_mod(word_t base, word_t e, word_t m);
    word_t acc;
    word_t sq;
    acc = word_t'(1) % m;
    sq  = base % m;
    for (int i = 0; i < WORD_BITS; i++) begin
      if (e[i]) begin
        acc = mul_mod(acc, sq, m);
      end
      sq = mul_mod(sq, sq, m);
    end
    return acc;
  endfunction

  function automatic cipher_t predict_cipher(word_t m, word_t k);
    cipher_t c;
    c = '0;
    if (key_p >= 2) begin
      c.c1 = pow_mod(key_g, k, key_p);
      c.c2 = mul_mod(m % key_p, pow_mod(key_y, k, key_p), key_p);
    end
    return c;
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && valid_o) begin
      if (pending_ciphers.size() == 0) begin
        $error("result with no transaction pending: c1=%h c2=%h", cipher_c1_o, cipher_c2_o);
        error_count++;
      end else begin
        if (cipher_c1_o !== pending_ciphers[0].c1) begin
          $error("cipher_c1: expected %h, got %h", pending_ciphers[0].c1, cipher_c1_o);
          error_count++;
        end
        if (cipher_c2_o !== pending_ciphers[0].c2) begin
          $error("cipher_c2: expected %h, got %h", pending_ciphers[0].c2, cipher_c2_o);
          error_count++;
        end
        void'(pending_ciphers.pop_front());
        ciphers_checked++;
      end
    end
  end

  task automatic send_item(word_t m, word_t k, logic typed, cipher_t typed_res);
    if ($urandom_range(0, 99) < gap_percent) begin
      start <= 1'b0;
      repeat ($urandom_range(0, 1) ? $urandom_range(1, 8) : $urandom_range(1, LONG_GAP_MAX))
        @(posedge clk_i);
    end
    start         <= 1'b1;
    plaintext_i   <= m;
    ephemeral_k_i <= k;
    do @(posedge clk_i); while (busy);
    pending_ciphers.push_back(typed ? typed_res : predict_cipher(m, k));
  endtask

  task automatic drain();
    start <= 1'b0;
    do @(posedge clk_i); while (pending_ciphers.size() != 0 || busy);
    @(posedge clk_i);
  endtask

  task automatic write_reg(egm_reg_idx_t idx, word_t value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    case (idx)
      REG_MODULUS_P:   key_p = value;
      REG_GENERATOR_G: key_g = value;
      REG_PUBLIC_Y:    key_y = value;
      default: ;
    endcase
  endtask

  task automatic set_key(word_t p, word_t g, word_t y);
    drain();
    write_reg(REG_MODULUS_P, p);
    write_reg(REG_GENERATOR_G, g);
    write_reg(REG_PUBLIC_Y, y);
    write_reg(REG_UNMAPPED, $urandom);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    key_changes++;
  endtask

  initial begin
    vector_t v;
    word_t   p;
    word_t   g;
    word_t   y;
    word_t   m;
    word_t   k;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    foreach (directed_vectors[i]) begin
      v = directed_vectors[i];
      if (v.p != key_p || v.g != key_g || v.y != key_y) begin
        set_key(v.p, v.g, v.y);
      end
      send_item(v.m, v.k, v.typed, v.res);
    end

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      case ($urandom_range(0, 5))
        0:       p = 32'hFFFFFFFB;
        1:       p = '1;
        2:       p = $urandom_range(3, 1000);
        3:       p = 32'h80000000 | $urandom;
        default: p = $urandom;
      endcase
      if (p < 3) begin
        p = 3;
      end
      g = ($urandom_range(0, 3) == 0) ? word_t'($urandom) : word_t'($urandom % p);
      y = ($urandom_range(0, 3) == 0) ? word_t'($urandom) : word_t'($urandom % p);
      set_key(p, g, y);
      gap_percent = (ph < 2) ? 29 : (ph < 4) ? 45 : 0;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        case ($urandom_range(0, 4))
          0, 1:    m = $urandom;
          2:       m = key_p - 1;
          3:       m = key_p + $urandom_range(0, 3);
          default: m = $urandom_range(0, 1) ? '0 : '1;
        endcase
        case ($urandom_range(0, 5))
          0, 1, 2: k = $urandom;
          3:       k = $urandom_range(0, 3);
          4:       k = '1;
          default: k = $urandom & $urandom & $urandom;
        endcase
        send_item(m, k, 1'b0, '0);
      end
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    $display("checked %0d transactions over %0d public keys", ciphers_checked, key_changes);
    $display("keys spanned degenerate, tiny, composite and full-width prime moduli");
    if (error_count == 0 && pending_ciphers.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #(2 * TIMEOUT_CYCLES);
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

### elgamal_encrypt_modexp_core.f
rtl/core/egm_pkg.sv
rtl/core/egm_modmul.sv
rtl/core/elgamal_encrypt_modexp_core.sv
bench/tb_elgamal_encrypt_modexp_core.sv
